### hw/rtl/tfcw_pkg.sv
`default_nettype none
package tfcw_pkg;

  localparam int unsigned FLOWS  = 1024;
  localparam int unsigned SLOT_W = $clog2(FLOWS);

  localparam logic [7:0]  FLAG_FIN = 8'h01;
  localparam logic [7:0]  FLAG_SYN = 8'h02;
  localparam logic [7:0]  FLAG_RST = 8'h04;
  localparam logic [7:0]  FLAG_ACK = 8'h10;
  localparam logic [31:0] BW_RTT_CAP = 32'd1000000;
  localparam logic [31:0] MS_SCALE = 32'd1000;
  // For any 32-bit x, x / 1000000 equals ((x >> 6) * BW_RECIP) >> 40.
  localparam logic [26:0] BW_RECIP = 27'd70368745;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ECN_ENABLE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RTT_LIMIT         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUP_ACK_LIMIT     = 3'd6;

  typedef struct packed {
    logic [9:0]  flow_slot;
    logic [7:0]  seg_flags;
    logic [31:0] ack_number;
    logic [1:0]  ecn_mark;
    logic [63:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [31:0] window;
    logic [31:0] threshold;
    logic        phase;
    logic [31:0] rtt_us;
    logic [31:0] rtt_floor_us;
    logic [31:0] bandwidth_estimate;
    logic        flow_created;
    logic        flow_removed;
    logic [63:0] mean_window;
    logic [63:0] mean_rtt;
    logic [63:0] connections_seen;
    logic [63:0] avoidance_entries;
  } result_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_CAPTURE, CMD_LOAD, CMD_ACK, CMD_DIV_AVOID, CMD_ADD_AVOID,
    CMD_CLAMP, CMD_DIV_BW, CMD_BW, CMD_MUL_W, CMD_DIV_W, CMD_WCLAMP, CMD_FIN1, CMD_FIN2
  } cmd_e;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic avoid_need;
    logic clamp_need;
    logic bw_need;
    logic w_need;
  } status_t;

endpackage
`default_nettype wire

### hw/rtl/tcp_flow_congestion_window.sv
`default_nettype none
// Per-flow Reno-style congestion window tracker.
// Input channel: the caller raises start_i with one segment event on in_item_i;
// the transaction is taken at a clock edge where start_i is high and busy_o is
// low. The flow slot comes from an external classifier.
// Result channel: one result per event is shown on result_o for exactly one
// cycle with result_valid_o high. The receiver cannot stall; it must take the
// result in that cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i write
// one register; cfg_ready_o is always high. Writes are meant for idle times.
// Sequence: an accepted event steps through capture, load, ACK handling and the
// two finish states; a fresh ACK may add the avoidance division, the clamp, the
// bandwidth division and the window clamp. The shared 32-bit radix-2 divider gives
// one quotient bit per cycle; the division by one million is a reciprocal multiply.
// One event is in flight at a time and the next one may be taken in the strobe
// cycle.
// Reset: after rst_ni is released the flow table is swept once, all 1024 entries,
// one entry per cycle, with busy_o high; configuration writes are still taken.
// Registers, global counters and means return to their reset values.
module tcp_flow_congestion_window (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire tfcw_pkg::in_item_t             in_item_i,
  output logic                                result_valid_o,
  output tfcw_pkg::result_t                   result_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tfcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i
);

  tfcw_pkg::cmd_e    cmd;
  tfcw_pkg::status_t status;

  // The register file is always ready for a write transaction.
  assign cfg_ready_o = 1'b1;

  tfcw_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .status_i(status), .cmd_o(cmd), .busy_o, .result_valid_o
  );

  tfcw_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .status_o(status), .in_item_i,
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .result_o
  );

endmodule
`default_nettype wire

### hw/rtl/tfcw_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The divisor is never zero here.
module tfcw_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic [31:0]      quotient_o,
  output logic             done_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [31:0] r_q, r_d, q_q, q_d, d_q, d_d;
  logic [32:0] trial;

  assign trial = {r_q, q_q[31]} - {1'b0, d_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    r_d    = r_q;
    q_d    = q_q;
    d_d    = d_q;
    if (start_i) begin
      cnt_d = 6'd32;
      r_d   = '0;
      q_d   = dividend_i;
      d_d   = divisor_i;
    end else if (cnt_q != 6'd0) begin
      r_d    = trial[32] ? {r_q[30:0], q_q[31]} : trial[31:0];
      q_d    = {q_q[30:0], ~trial[32]};
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    d_q <= d_d;
  end

  assign quotient_o = q_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

### hw/rtl/tfcw_dp.sv
`default_nettype none
// Flow table, working copy of one entry, configuration and global counters.
module tfcw_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tfcw_pkg::cmd_e                   cmd_i,
  output tfcw_pkg::status_t                     status_o,
  input  wire tfcw_pkg::in_item_t               in_item_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [tfcw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                      cfg_data_i,
  output tfcw_pkg::result_t                     result_o
);

  typedef struct packed {
    logic        valid;
    logic [31:0] win;
    logic [31:0] thr;
    logic        ph;
    logic [7:0]  dup;
    logic [31:0] lack;
    logic [63:0] ltime;
    logic [31:0] rtt;
    logic [31:0] flr;
    logic [31:0] bw;
    logic [31:0] crtt;
  } entry_t;

  entry_t mem [tfcw_pkg::FLOWS];
  entry_t rd_q, e_q, e_d;
  tfcw_pkg::in_item_t in_q;
  tfcw_pkg::result_t  out_q;

  logic [tfcw_pkg::SLOT_W-1:0] clr_q;
  logic [15:0] mss_q;
  logic [31:0] iwin_q, ithr_q, rlim_q;
  logic        ecn_en_q, clamp_en_q;
  logic [7:0]  dlim_q;
  logic [63:0] conn_q, conn_d, avoid_q, avoid_d, mw_q, mw_d, mr_q, mr_d;
  logic        created_q, created_d, fresh_q, fresh_d, avn_q, avn_d;
  logic [31:0] prod_q, prod_d;
  logic        div_start;
  logic [31:0] div_a, div_b, quo;
  logic        div_done;
  logic        pure_ack, is_rst, is_syn_only, wr_en;
  logic [7:0]  dup_inc;
  logic [31:0] w_tmp, r_tmp, mss32;
  logic [33:0] w3;
  logic [52:0] recip_prod;
  entry_t      wr_data;

  assign mss32    = {16'd0, mss_q};
  assign pure_ack = ((in_q.seg_flags & tfcw_pkg::FLAG_ACK) != 8'h00) &&
                    ((in_q.seg_flags & (tfcw_pkg::FLAG_SYN | tfcw_pkg::FLAG_FIN |
                                        tfcw_pkg::FLAG_RST)) == 8'h00);
  assign is_rst   = (in_q.seg_flags & tfcw_pkg::FLAG_RST) != 8'h00;
  assign is_syn_only = ((in_q.seg_flags & tfcw_pkg::FLAG_SYN) != 8'h00) &&
                       ((in_q.seg_flags & tfcw_pkg::FLAG_ACK) == 8'h00);
  assign dup_inc  = e_q.dup + 8'd1;
  // Division of the bandwidth-delay product by one million as a reciprocal multiply.
  assign recip_prod = 53'(prod_q[31:6]) * 53'(tfcw_pkg::BW_RECIP);

  always_comb begin
    div_start = 1'b0;
    div_a     = prod_q;
    div_b     = e_q.rtt;
    case (cmd_i)
      tfcw_pkg::CMD_DIV_AVOID: begin
        div_start = 1'b1;
        div_a     = 32'(mss32 * mss32);
        div_b     = e_q.win;
      end
      tfcw_pkg::CMD_DIV_BW: div_start = 1'b1;
      default: ;
    endcase
  end

  tfcw_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .quotient_o(quo), .done_o(div_done)
  );

  always_comb begin
    e_d       = e_q;
    conn_d    = conn_q;
    avoid_d   = avoid_q;
    mw_d      = mw_q;
    mr_d      = mr_q;
    created_d = created_q;
    fresh_d   = fresh_q;
    avn_d     = avn_q;
    prod_d    = prod_q;
    w_tmp     = '0;
    r_tmp     = '0;
    w3        = '0;
    wr_en     = 1'b0;
    wr_data   = e_q;
    case (cmd_i)
      tfcw_pkg::CMD_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      tfcw_pkg::CMD_LOAD: begin
        fresh_d = 1'b0;
        avn_d   = 1'b0;
        if (!rd_q.valid) begin
          e_d       = '0;
          e_d.valid = 1'b1;
          e_d.win   = iwin_q;
          e_d.thr   = ithr_q;
          e_d.ltime = in_q.now_us;
          conn_d    = conn_q + 64'd1;
          created_d = 1'b1;
        end else begin
          e_d       = rd_q;
          created_d = 1'b0;
        end
      end
      tfcw_pkg::CMD_ACK: begin
        if (pure_ack) begin
          if (in_q.ack_number == e_q.lack) begin
            e_d.dup = dup_inc;
            if (dup_inc >= dlim_q) begin
              e_d.dup = '0;
              w_tmp   = {1'b0, e_q.win[31:1]};
              e_d.win = (w_tmp < mss32) ? mss32 : w_tmp;
            end
          end else begin
            fresh_d  = 1'b1;
            avn_d    = e_q.ph && (e_q.win != 32'd0);
            e_d.dup  = '0;
            e_d.lack = in_q.ack_number;
            if (in_q.now_us > e_q.ltime) begin
              r_tmp = 32'(in_q.now_us - e_q.ltime);
              if (r_tmp < rlim_q) begin
                e_d.rtt = r_tmp;
                if (e_q.flr == 32'd0 || r_tmp < e_q.flr) e_d.flr = r_tmp;
              end
            end
            if (!e_q.ph) begin
              w_tmp   = e_q.win + mss32;
              e_d.win = w_tmp;
              if (w_tmp >= e_q.thr) begin
                e_d.ph  = 1'b1;
                avoid_d = avoid_q + 64'd1;
              end
            end
          end
        end
      end
      tfcw_pkg::CMD_ADD_AVOID: e_d.win = e_q.win + quo;
      tfcw_pkg::CMD_CLAMP: begin
        if (e_q.crtt == 32'd0 || e_q.rtt < e_q.crtt) e_d.crtt = e_q.rtt;
        prod_d = 32'(e_q.win * tfcw_pkg::MS_SCALE);
      end
      tfcw_pkg::CMD_BW: if (quo > e_q.bw) e_d.bw = quo;
      tfcw_pkg::CMD_MUL_W: prod_d = 32'(e_q.bw * e_q.crtt);
      tfcw_pkg::CMD_DIV_W: prod_d = {19'd0, recip_prod[52:40]};
      tfcw_pkg::CMD_WCLAMP: if (prod_q != 32'd0 && prod_q < e_q.win) e_d.win = prod_q;
      tfcw_pkg::CMD_FIN1: begin
        w_tmp = e_q.win;
        if (is_syn_only) begin
          e_d.ph  = 1'b0;
          e_d.thr = ithr_q;
          w_tmp   = mss32;
        end
        e_d.win = w_tmp;
        if (!is_rst && ecn_en_q && in_q.ecn_mark != 2'd0) begin
          w3      = {2'b00, w_tmp} + {1'b0, w_tmp, 1'b0};
          w_tmp   = (w3[31:2] < mss32[29:0]) ? mss32 : {2'b00, w3[31:2]};
          e_d.win = w_tmp;
          if (e_d.thr > w_tmp) e_d.thr = w_tmp;
          e_d.ph  = 1'b1;
        end
      end
      tfcw_pkg::CMD_FIN2: begin
        wr_en = 1'b1;
        if (is_rst) begin
          wr_data.valid = 1'b0;
        end else begin
          e_d.ltime     = in_q.now_us;
          wr_data.ltime = in_q.now_us;
          if (e_q.win != 32'd0) begin
            mw_d = 64'((65'(mw_q) + 65'(e_q.win)) >> 1);
            if (e_q.rtt != 32'd0) mr_d = 64'((65'(mr_q) + 65'(e_q.rtt)) >> 1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == tfcw_pkg::CMD_CAPTURE) begin
      rd_q <= mem[in_item_i.flow_slot];
      in_q <= in_item_i;
    end
    if (wr_en) begin
      if (cmd_i == tfcw_pkg::CMD_CLEAR) mem[clr_q] <= wr_data;
      else mem[in_q.flow_slot] <= wr_data;
    end
    e_q    <= e_d;
    prod_q <= prod_d;
    fresh_q <= fresh_d;
    avn_q   <= avn_d;
    created_q <= created_d;
    if (cmd_i == tfcw_pkg::CMD_FIN2) begin
      out_q.window             <= e_q.win;
      out_q.threshold          <= e_q.thr;
      out_q.phase              <= e_q.ph;
      out_q.rtt_us             <= e_q.rtt;
      out_q.rtt_floor_us       <= e_q.flr;
      out_q.bandwidth_estimate <= e_q.bw;
      out_q.flow_created       <= created_q;
      out_q.flow_removed       <= is_rst;
      out_q.mean_window        <= mw_d;
      out_q.mean_rtt           <= mr_d;
      out_q.connections_seen   <= conn_q;
      out_q.avoidance_entries  <= avoid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      mss_q      <= 16'd1460;
      iwin_q     <= 32'd14600;
      ithr_q     <= 32'd65535;
      ecn_en_q   <= 1'b1;
      clamp_en_q <= 1'b1;
      rlim_q     <= 32'd1000000;
      dlim_q     <= 8'd3;
      conn_q     <= '0;
      avoid_q    <= '0;
      mw_q       <= '0;
      mr_q       <= '0;
    end else begin
      if (cmd_i == tfcw_pkg::CMD_CLEAR) clr_q <= clr_q + 1'b1;
      conn_q  <= conn_d;
      avoid_q <= avoid_d;
      mw_q    <= mw_d;
      mr_q    <= mr_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tfcw_pkg::REG_SEGMENT_SIZE:      mss_q      <= cfg_data_i[15:0];
          tfcw_pkg::REG_INITIAL_WINDOW:    iwin_q     <= cfg_data_i;
          tfcw_pkg::REG_INITIAL_THRESHOLD: ithr_q     <= cfg_data_i;
          tfcw_pkg::REG_ECN_ENABLE:        ecn_en_q   <= cfg_data_i[0];
          tfcw_pkg::REG_CLAMP_ENABLE:      clamp_en_q <= cfg_data_i[0];
          tfcw_pkg::REG_RTT_LIMIT:         rlim_q     <= cfg_data_i;
          tfcw_pkg::REG_DUP_ACK_LIMIT:     dlim_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  assign status_o.clear_last = (clr_q == tfcw_pkg::SLOT_W'(tfcw_pkg::FLOWS - 1));
  assign status_o.div_done   = div_done;
  assign status_o.avoid_need = avn_q;
  assign status_o.clamp_need = fresh_q && clamp_en_q && (e_q.rtt != 32'd0);
  assign status_o.bw_need    = e_q.rtt < tfcw_pkg::BW_RTT_CAP;
  assign status_o.w_need     = (e_q.bw != 32'd0) && (e_q.crtt != 32'd0);
  assign result_o            = out_q;

endmodule
`default_nettype wire

### hw/rtl/tfcw_ctrl.sv
`default_nettype none
// Sequencer for one segment event at a time.
module tfcw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tfcw_pkg::status_t status_i,
  output tfcw_pkg::cmd_e         cmd_o,
  output logic                   busy_o,
  output logic                   result_valid_o
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_ACK, ST_DIV1, ST_WAIT1, ST_ADD, ST_CLAMP, ST_DIV2,
    ST_WAIT2, ST_BW, ST_MUL, ST_DIV3, ST_WCLAMP, ST_FIN1, ST_FIN2
  } state_e;

  state_e state_q, state_d;
  logic   valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = tfcw_pkg::CMD_NONE;
    case (state_q)
      ST_CLEAR: begin
        cmd_o = tfcw_pkg::CMD_CLEAR;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: if (start_i) begin
        cmd_o   = tfcw_pkg::CMD_CAPTURE;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o   = tfcw_pkg::CMD_LOAD;
        state_d = ST_ACK;
      end
      ST_ACK: begin
        cmd_o   = tfcw_pkg::CMD_ACK;
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        if (status_i.avoid_need) begin
          cmd_o   = tfcw_pkg::CMD_DIV_AVOID;
          state_d = ST_WAIT1;
        end else begin
          state_d = status_i.clamp_need ? ST_CLAMP : ST_FIN1;
        end
      end
      ST_WAIT1: if (status_i.div_done) state_d = ST_ADD;
      ST_ADD: begin
        cmd_o   = tfcw_pkg::CMD_ADD_AVOID;
        state_d = status_i.clamp_need ? ST_CLAMP : ST_FIN1;
      end
      ST_CLAMP: begin
        cmd_o   = tfcw_pkg::CMD_CLAMP;
        state_d = status_i.bw_need ? ST_DIV2 : ST_MUL;
      end
      ST_DIV2: begin
        cmd_o   = tfcw_pkg::CMD_DIV_BW;
        state_d = ST_WAIT2;
      end
      ST_WAIT2: if (status_i.div_done) state_d = ST_BW;
      ST_BW: begin
        cmd_o   = tfcw_pkg::CMD_BW;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o   = tfcw_pkg::CMD_MUL_W;
        state_d = status_i.w_need ? ST_DIV3 : ST_FIN1;
      end
      ST_DIV3: begin
        cmd_o   = tfcw_pkg::CMD_DIV_W;
        state_d = ST_WCLAMP;
      end
      ST_WCLAMP: begin
        cmd_o   = tfcw_pkg::CMD_WCLAMP;
        state_d = ST_FIN1;
      end
      ST_FIN1: begin
        cmd_o   = tfcw_pkg::CMD_FIN1;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o   = tfcw_pkg::CMD_FIN2;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == ST_FIN2);
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

endmodule
`default_nettype wire

### hw/rtl/tfcw_checker.sv
`default_nettype none
module tfcw_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic result_valid_o,
  input wire logic cfg_ready_o
);

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accept did not raise busy");

  // A result never follows its own acceptance in the next cycle.
  a_accept_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !result_valid_o) else $error("result too early");

  // Result strobes are single-cycle pulses.
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe too long");

  // A result strobe comes with the block returning to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$past(busy_o) || !busy_o) else $error("result while busy");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o) else $error("configuration port not ready");

endmodule

bind tcp_flow_congestion_window tfcw_checker u_tfcw_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .result_valid_o, .cfg_ready_o
);
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;

  // The gap that lets the block settle before a register write, and the tail
  // that is waited out after the last result.
  localparam int unsigned SETTLE_CYCLES = 24;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i;
  logic                 busy_o;
  tfcw_pkg::in_item_t   in_item;
  logic                 result_valid_o;
  tfcw_pkg::result_t    result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [tfcw_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  tcp_flow_congestion_window dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_item_i      (in_item),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // One pending transaction: either a segment event or a register write.
  typedef struct {
    bit                             is_write;
    logic [tfcw_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                    data;
    tfcw_pkg::in_item_t             ev;
  } pending_t;

  pending_t backlog[$];
  tfcw_pkg::result_t window_forecast[$];
  int unsigned mismatches = 0;

  // Our own copy of the register file.
  logic [31:0] mss, init_win, init_thr, rtt_limit;
  logic        ecn_on, clamp_on;
  logic [7:0]  dup_limit;

  // Our own copy of the flow table and the global counters.
  logic        f_valid [tfcw_pkg::FLOWS];
  logic [31:0] f_win [tfcw_pkg::FLOWS];
  logic [31:0] f_thr [tfcw_pkg::FLOWS];
  logic        f_phase [tfcw_pkg::FLOWS];
  logic [7:0]  f_dup [tfcw_pkg::FLOWS];
  logic [31:0] f_ack [tfcw_pkg::FLOWS];
  logic [63:0] f_time [tfcw_pkg::FLOWS];
  logic [31:0] f_rtt [tfcw_pkg::FLOWS];
  logic [31:0] f_floor [tfcw_pkg::FLOWS];
  logic [31:0] f_bw [tfcw_pkg::FLOWS];
  logic [31:0] f_crtt [tfcw_pkg::FLOWS];
  logic [63:0] conn_count, avoid_count, win_mean, rtt_mean;

  task automatic apply_setting(logic [tfcw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      tfcw_pkg::REG_SEGMENT_SIZE:      mss = {16'd0, data[15:0]};
      tfcw_pkg::REG_INITIAL_WINDOW:    init_win = data;
      tfcw_pkg::REG_INITIAL_THRESHOLD: init_thr = data;
      tfcw_pkg::REG_ECN_ENABLE:        ecn_on = data[0];
      tfcw_pkg::REG_CLAMP_ENABLE:      clamp_on = data[0];
      tfcw_pkg::REG_RTT_LIMIT:         rtt_limit = data;
      tfcw_pkg::REG_DUP_ACK_LIMIT:     dup_limit = data[7:0];
      default: ;
    endcase
  endtask

  // Bandwidth clamp: track the smallest RTT, keep the largest window per
  // millisecond, and pull the window down to bandwidth times that RTT.
  function automatic void clamp_window(int s, logic [31:0] rtt);
    logic [31:0] bw, w;
    if (f_crtt[s] == 0 || rtt < f_crtt[s]) f_crtt[s] = rtt;
    if (rtt > 0 && rtt < tfcw_pkg::BW_RTT_CAP) begin
      bw = (f_win[s] * tfcw_pkg::MS_SCALE) / rtt;
      if (bw > f_bw[s]) f_bw[s] = bw;
    end
    if (f_bw[s] > 0 && f_crtt[s] > 0) begin
      w = (f_bw[s] * f_crtt[s]) / tfcw_pkg::BW_RTT_CAP;
      if (w > 0 && w < f_win[s]) f_win[s] = w;
    end
  endfunction

  // A new acknowledgement: take an RTT sample, then slow start or additive
  // increase, then the clamp.
  function automatic void take_fresh_ack(int s, logic [31:0] ack, logic [63:0] now);
    logic [31:0] rtt;
    f_dup[s] = 8'd0;
    f_ack[s] = ack;
    if (now > f_time[s]) begin
      rtt = 32'(now - f_time[s]);
      if (rtt < rtt_limit) begin
        if (f_floor[s] == 0 || rtt < f_floor[s]) f_floor[s] = rtt;
        f_rtt[s] = rtt;
      end
    end
    if (!f_phase[s]) begin
      f_win[s] = f_win[s] + mss;
      if (f_win[s] >= f_thr[s]) begin
        f_phase[s] = 1'b1;
        avoid_count++;
      end
    end else if (f_win[s] != 0) begin
      f_win[s] = f_win[s] + (mss * mss) / f_win[s];
    end
    if (clamp_on && f_rtt[s] > 0) clamp_window(s, f_rtt[s]);
  endfunction

  // Updates the flow table for one accepted event and returns the result
  // the block has to show for it.
  function automatic tfcw_pkg::result_t advance_flow(tfcw_pkg::in_item_t ev);
    int                s;
    logic [31:0]       w;
    tfcw_pkg::result_t r;
    s = int'(ev.flow_slot) % tfcw_pkg::FLOWS;
    r = '0;
    if (!f_valid[s]) begin
      f_valid[s] = 1'b1;
      f_win[s] = init_win;
      f_thr[s] = init_thr;
      f_phase[s] = 1'b0;
      f_dup[s] = 8'd0;
      f_ack[s] = 32'd0;
      f_time[s] = ev.now_us;
      f_rtt[s] = 32'd0;
      f_floor[s] = 32'd0;
      f_bw[s] = 32'd0;
      f_crtt[s] = 32'd0;
      conn_count++;
      r.flow_created = 1'b1;
    end
    // Pure ACK: ACK with none of SYN, FIN and RST.
    if ((ev.seg_flags & tfcw_pkg::FLAG_ACK) != 0 &&
        (ev.seg_flags & (tfcw_pkg::FLAG_SYN | tfcw_pkg::FLAG_FIN | tfcw_pkg::FLAG_RST)) == 0)
    begin
      if (ev.ack_number == f_ack[s]) begin
        f_dup[s] = f_dup[s] + 8'd1;
        if (f_dup[s] >= dup_limit) begin
          f_dup[s] = 8'd0;
          f_win[s] = f_win[s] / 2;
          if (f_win[s] < mss) f_win[s] = mss;
        end
      end else begin
        take_fresh_ack(s, ev.ack_number, ev.now_us);
      end
    end
    if ((ev.seg_flags & tfcw_pkg::FLAG_SYN) != 0 && (ev.seg_flags & tfcw_pkg::FLAG_ACK) == 0)
    begin
      f_phase[s] = 1'b0;
      f_win[s] = mss;
      f_thr[s] = init_thr;
    end
    if ((ev.seg_flags & tfcw_pkg::FLAG_RST) != 0) begin
      f_valid[s] = 1'b0;
      r.flow_removed = 1'b1;
    end else begin
      if (ecn_on && ev.ecn_mark != 0) begin
        w = (f_win[s] * 32'd3) / 32'd4;
        if (w < mss) w = mss;
        f_win[s] = w;
        if (f_thr[s] > w) f_thr[s] = w;
        f_phase[s] = 1'b1;
      end
      f_time[s] = ev.now_us;
      if (f_win[s] > 0) begin
        win_mean = (win_mean + 64'(f_win[s])) / 2;
        if (f_rtt[s] > 0) rtt_mean = (rtt_mean + 64'(f_rtt[s])) / 2;
      end
    end
    r.window = f_win[s];
    r.threshold = f_thr[s];
    r.phase = f_phase[s];
    r.rtt_us = f_rtt[s];
    r.rtt_floor_us = f_floor[s];
    r.bandwidth_estimate = f_bw[s];
    r.mean_window = win_mean;
    r.mean_rtt = rtt_mean;
    r.connections_seen = conn_count;
    r.avoidance_entries = avoid_count;
    return r;
  endfunction

  // Most gaps are short, a few are long, and about half are none at all.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic push_write(logic [tfcw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    pending_t p;
    p.is_write = 1'b1;
    p.idx = idx;
    p.data = data;
    p.ev = '0;
    backlog.push_back(p);
  endtask

  task automatic push_event(logic [9:0] slot, logic [7:0] flags, logic [31:0] ack,
                            logic [1:0] ecn, logic [63:0] now);
    pending_t p;
    p.is_write = 1'b0;
    p.idx = tfcw_pkg::REG_SEGMENT_SIZE;
    p.data = 32'd0;
    p.ev.flow_slot = slot;
    p.ev.seg_flags = flags;
    p.ev.ack_number = ack;
    p.ev.ecn_mark = ecn;
    p.ev.now_us = now;
    backlog.push_back(p);
  endtask

  task automatic push_settings(logic [31:0] seg, logic [31:0] iw, logic [31:0] it,
                               logic ecn, logic clamp, logic [31:0] rl, logic [7:0] dl);
    push_write(tfcw_pkg::REG_SEGMENT_SIZE, seg);
    push_write(tfcw_pkg::REG_INITIAL_WINDOW, iw);
    push_write(tfcw_pkg::REG_INITIAL_THRESHOLD, it);
    push_write(tfcw_pkg::REG_ECN_ENABLE, {31'd0, ecn});
    push_write(tfcw_pkg::REG_CLAMP_ENABLE, {31'd0, clamp});
    push_write(tfcw_pkg::REG_RTT_LIMIT, rl);
    push_write(tfcw_pkg::REG_DUP_ACK_LIMIT, {24'd0, dl});
  endtask

  // Generator state: a running clock and the last ACK sent on each slot, so
  // that most traffic is a believable connection with rising ACK numbers.
  logic [63:0] gen_now = 64'd5000;
  logic [31:0] gen_ack [tfcw_pkg::FLOWS];

  task automatic push_traffic(int unsigned count);
    logic [9:0]  pool [6];
    logic [9:0]  s;
    logic [7:0]  flags;
    logic [31:0] ack;
    logic [1:0]  ecn;
    int unsigned roll;
    foreach (pool[i]) pool[i] = 10'($urandom_range(0, tfcw_pkg::FLOWS - 1));
    pool[0] = 10'd0;
    pool[1] = 10'(tfcw_pkg::FLOWS - 1);
    for (int unsigned n = 0; n < count; n++) begin
      s = pool[$urandom_range(0, 5)];
      roll = $urandom_range(0, 99);
      gen_now = gen_now + (($urandom_range(0, 49) == 0) ? 64'($urandom_range(900000, 3000000))
                                                         : 64'($urandom_range(1, 3000)));
      ecn = ($urandom_range(0, 99) < 85) ? 2'd0 : 2'($urandom_range(1, 3));
      ack = gen_ack[s];
      if (roll < 55) begin
        ack = gen_ack[s] + $urandom_range(1, 3000);
        gen_ack[s] = ack;
        flags = ($urandom_range(0, 1) == 0) ? tfcw_pkg::FLAG_ACK
                                            : (tfcw_pkg::FLAG_ACK | 8'h08);
      end else if (roll < 70) begin
        flags = tfcw_pkg::FLAG_ACK;
      end else if (roll < 76) begin
        flags = tfcw_pkg::FLAG_SYN;
      end else if (roll < 79) begin
        flags = tfcw_pkg::FLAG_SYN | tfcw_pkg::FLAG_ACK;
      end else if (roll < 83) begin
        flags = tfcw_pkg::FLAG_RST | (($urandom_range(0, 1) == 0) ? 8'h00 : tfcw_pkg::FLAG_ACK);
      end else if (roll < 86) begin
        flags = tfcw_pkg::FLAG_FIN | tfcw_pkg::FLAG_ACK;
      end else begin
        // Noise: any slot, any flags, any ACK, sometimes any time stamp.
        s = 10'($urandom);
        flags = 8'($urandom);
        ack = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          push_event(s, flags, ack, ecn, {$urandom, $urandom});
          continue;
        end
      end
      push_event(s, flags, ack, ecn, gen_now);
    end
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(field, got, want);
  endtask

  // Driver. Items and writes come off the backlog in order. A register write
  // waits until every forecast result has arrived and the block has been
  // quiet for a while. Each signal gets exactly one assignment per edge, so
  // a start that stays high for back to back items is never dropped.
  int unsigned gap, quiet;

  always @(posedge clk_i or negedge rst_ni) begin
    logic        launch, writing;
    int unsigned gap_n, quiet_n;
    if (!rst_ni) begin
      start_i <= 1'b0;
      in_item <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= tfcw_pkg::REG_SEGMENT_SIZE;
      cfg_data_i <= 32'd0;
      gap <= 0;
      quiet <= 0;
    end else begin
      launch = start_i;
      writing = cfg_valid_i;
      gap_n = gap;
      if (start_i && !busy_o) begin
        window_forecast.push_back(advance_flow(in_item));
        launch = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_setting(cfg_index_i, cfg_data_i);
        writing = 1'b0;
      end
      if (window_forecast.size() == 0 && !start_i && !busy_o)
        quiet_n = (quiet < SETTLE_CYCLES) ? quiet + 1 : quiet;
      else
        quiet_n = 0;
      if (gap_n != 0) begin
        gap_n--;
      end else if (!launch && !writing && backlog.size() > 0) begin
        if (backlog[0].is_write) begin
          if (quiet >= SETTLE_CYCLES && !start_i) begin
            cfg_index_i <= backlog[0].idx;
            cfg_data_i <= backlog[0].data;
            writing = 1'b1;
            void'(backlog.pop_front());
          end
        end else begin
          in_item <= backlog[0].ev;
          launch = 1'b1;
          void'(backlog.pop_front());
          gap_n = pick_gap();
        end
      end
      start_i <= launch;
      cfg_valid_i <= writing;
      gap <= gap_n;
      quiet <= quiet_n;
    end
  end

  // Monitor: every strobed result is compared with the oldest forecast.
  always @(posedge clk_i) begin
    tfcw_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      if (window_forecast.size() == 0) begin
        report("unexpected result", 64'(result_o.window), 64'd0);
      end else begin
        want = window_forecast.pop_front();
        check_field("window", 64'(result_o.window), 64'(want.window));
        check_field("threshold", 64'(result_o.threshold), 64'(want.threshold));
        check_field("phase", 64'(result_o.phase), 64'(want.phase));
        check_field("rtt_us", 64'(result_o.rtt_us), 64'(want.rtt_us));
        check_field("rtt_floor_us", 64'(result_o.rtt_floor_us), 64'(want.rtt_floor_us));
        check_field("bandwidth_estimate", 64'(result_o.bandwidth_estimate),
                    64'(want.bandwidth_estimate));
        check_field("flow_created", 64'(result_o.flow_created), 64'(want.flow_created));
        check_field("flow_removed", 64'(result_o.flow_removed), 64'(want.flow_removed));
        check_field("mean_window", result_o.mean_window, want.mean_window);
        check_field("mean_rtt", result_o.mean_rtt, want.mean_rtt);
        check_field("connections_seen", result_o.connections_seen, want.connections_seen);
        check_field("avoidance_entries", result_o.avoidance_entries,
                    want.avoidance_entries);
      end
    end
  end

  initial begin
    mss = 32'd1460;
    init_win = 32'd14600;
    init_thr = 32'd65535;
    ecn_on = 1'b1;
    clamp_on = 1'b1;
    rtt_limit = 32'd1000000;
    dup_limit = 8'd3;
    conn_count = '0;
    avoid_count = '0;
    win_mean = '0;
    rtt_mean = '0;
    foreach (f_valid[i]) begin
      f_valid[i] = 1'b0;
      gen_ack[i] = 32'd0;
    end

    // Directed part at the reset settings: create, fresh ACK, three
    // duplicates that halve the window, ECN, FIN, SYN with and without
    // ACK, RST on a live slot and on a fresh one, and the field extremes.
    push_event(10'd5, tfcw_pkg::FLAG_SYN, 32'd0, 2'd0, 64'd1000);
    push_event(10'd5, tfcw_pkg::FLAG_ACK, 32'd100, 2'd0, 64'd1200);
    push_event(10'd5, tfcw_pkg::FLAG_ACK, 32'd100, 2'd0, 64'd1300);
    push_event(10'd5, tfcw_pkg::FLAG_ACK, 32'd100, 2'd0, 64'd1400);
    push_event(10'd5, tfcw_pkg::FLAG_ACK, 32'd100, 2'd0, 64'd1450);
    push_event(10'd5, tfcw_pkg::FLAG_ACK, 32'd200, 2'd0, 64'd1500);
    push_event(10'd5, tfcw_pkg::FLAG_ACK, 32'd300, 2'd1, 64'd1900);
    push_event(10'd5, tfcw_pkg::FLAG_ACK | tfcw_pkg::FLAG_FIN, 32'd400, 2'd0, 64'd2000);
    push_event(10'd5, tfcw_pkg::FLAG_ACK | tfcw_pkg::FLAG_SYN, 32'd500, 2'd2, 64'd2100);
    push_event(10'd9, tfcw_pkg::FLAG_RST, 32'd7, 2'd3, 64'd2200);
    push_event(10'd5, tfcw_pkg::FLAG_RST | tfcw_pkg::FLAG_ACK, 32'd600, 2'd1, 64'd2300);
    push_event(10'd1023, 8'hFF, 32'hFFFF_FFFF, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    push_event(10'd0, 8'h00, 32'd0, 2'd0, 64'd0);
    push_event(10'd0, tfcw_pkg::FLAG_ACK, 32'd1, 2'd0, 64'hFFFF_FFFF_0000_0000);
    push_event(10'd0, tfcw_pkg::FLAG_ACK, 32'd2, 2'd0, 64'd5);
    push_event(10'd0, tfcw_pkg::FLAG_ACK, 32'd3, 2'd0, 64'd400);
    push_event(10'd512, tfcw_pkg::FLAG_ACK, 32'h8000_0000, 2'd0, 64'd100);
    push_event(10'd512, tfcw_pkg::FLAG_ACK, 32'h8000_0001, 2'd0, 64'd700);
    push_event(10'd512, tfcw_pkg::FLAG_SYN, 32'd0, 2'd0, 64'd800);

    // Lowest settings, then highest, then the reset values again.
    push_settings(32'd1, 32'd1, 32'd1, 1'b0, 1'b0, 32'd1, 8'd1);
    push_traffic(150);
    push_settings(32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                  32'hFFFF_FFFF, 8'd255);
    push_traffic(150);
    push_settings(32'd1460, 32'd14600, 32'd65535, 1'b1, 1'b1, 32'd1000000, 8'd3);
    push_traffic(300);
    for (int k = 0; k < 4; k++) begin
      push_settings($urandom_range(1, 65535), ($urandom_range(0, 1) == 0)
                      ? $urandom_range(1, 100000) : $urandom,
                    ($urandom_range(0, 1) == 0) ? $urandom_range(1, 200000) : $urandom,
                    1'($urandom), 1'($urandom),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4000) : $urandom,
                    8'($urandom_range(1, 255)));
      push_traffic(160);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the backlog to drain and every forecast to be met, then give
    // the block a short tail before the verdict.
    @(negedge clk_i);
    while (backlog.size() != 0 || window_forecast.size() != 0 || start_i || cfg_valid_i)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // The slowest legal run is about 1300 events on the longest path plus long gaps
  // and the table sweep after reset, under 1 ms; allow several times that.
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
